// File: hdl/ptts_pkg.sv
// ----------------------------------------------------------------------------
// Periodic task tick scheduler package
// Shared types and constants: opcodes, beat payloads and the sequencer states.
// ----------------------------------------------------------------------------
package ptts_pkg;

   // Default number of task slots
   localparam int TASK_SLOTS_DEF = 8;

   // At most this many result beats per tick
   localparam int MAX_RESULTS = 8;
   localparam int RES_W       = $clog2(MAX_RESULTS);

   // Field widths
   localparam int OPCODE_W = 3;
   localparam int INDEX_W  = 3;
   localparam int TIME_W   = 16;

   typedef enum logic [OPCODE_W-1:0] {
      OP_TICK    = 3'd0,
      OP_CREATE  = 3'd1,
      OP_SUSPEND = 3'd2,
      OP_RESUME  = 3'd3,
      OP_DELETE  = 3'd4
   } opcode_type;

   typedef struct packed {
      logic [OPCODE_W-1:0] opcode;
      logic [INDEX_W-1:0]  task_index;
      logic [TIME_W-1:0]   period;
      logic [TIME_W-1:0]   first_delay;
   } req_type;

   typedef struct packed {
      logic               fire;
      logic [INDEX_W-1:0] task_id;
      logic               last;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_EMIT
   } state_type;

endpackage

// File: hdl/ptts_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module ptts_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Register read data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/periodic_task_tick_scheduler_core.sv
// ----------------------------------------------------------------------------
// Periodic task tick scheduler core
// Time-triggered task table: create, suspend, resume, delete and tick.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_stall/req_data) takes one command beat.
//   Create, suspend, resume and delete update the slot table in the accept
//   cycle and give no result. A tick walks every slot through one shared
//   decrement unit, one slot per cycle, reading countdown and period from
//   RAM with a one-deep read pipeline. Then a scan over the fired slots
//   sends one rsp beat per firing slot in index order (at most eight),
//   the final one marked last; a tick where nothing fired sends one beat
//   with fire low and last high. The scan moves one slot per cycle while
//   rsp is not stalled. req_stall is high from tick accept until the last
//   result is loaded into the output register.
//   A stalled rsp beat holds in the output register; the scan then waits
//   at the next fired slot.
//   Reset clears all flags and per-slot valid bits at once; a slot whose
//   countdown or period was never written reads as zero. No clearing pass.
// ----------------------------------------------------------------------------
module periodic_task_tick_scheduler_core
   import ptts_pkg::*;
#(
   parameter int TASK_SLOTS = TASK_SLOTS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int SLOT_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
   localparam int CNT_W  = $clog2(TASK_SLOTS + 1);

   // Sequencer and slot state
   state_type              state_ff, state_in;
   logic [CNT_W-1:0]       walk_ptr_ff, walk_ptr_in;
   logic                   rd_vld_ff, rd_vld_in;
   logic [SLOT_W-1:0]      rd_slot_ff, rd_slot_in;
   logic [TASK_SLOTS-1:0]  fired_ff, fired_in;
   logic [SLOT_W-1:0]      scan_ff, scan_in;
   logic [RES_W-1:0]       emit_cnt_ff, emit_cnt_in;
   logic [TASK_SLOTS-1:0]  active_ff, active_in;
   logic [TASK_SLOTS-1:0]  present_ff, present_in;
   logic [TASK_SLOTS-1:0]  cd_vld_ff, cd_vld_in;
   logic [TASK_SLOTS-1:0]  per_vld_ff, per_vld_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff, rsp_data_in;

   // RAM ports
   logic                   cd_wr_en;
   logic [SLOT_W-1:0]      cd_wr_addr;
   logic [TIME_W-1:0]      cd_wr_data;
   logic                   per_wr_en;
   logic                   rd_en;
   logic [SLOT_W-1:0]      rd_addr;
   logic [TIME_W-1:0]      cd_rdata;
   logic [TIME_W-1:0]      per_rdata;

   // Shared decrement unit
   logic [TIME_W-1:0]      cd_val;
   logic [TIME_W-1:0]      per_val;
   logic                   cd_zero;
   logic [TIME_W-1:0]      dec_opnd;
   logic [TIME_W-1:0]      dec_res;

   // Command decode
   logic                   req_accept;
   logic                   idx_ok;
   logic [SLOT_W-1:0]      req_slot;
   logic                   is_tick;
   logic                   walk_done;
   logic                   out_free;
   logic                   any_fired;
   logic                   cur_fired;
   logic                   cur_last;
   logic [TASK_SLOTS-1:0]  fired_rest;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign idx_ok     = ({4'd0, req_data.task_index} < 7'(TASK_SLOTS));
   assign req_slot   = SLOT_W'(req_data.task_index);
   assign is_tick    = (req_data.opcode == OP_TICK);
   assign walk_done  = (walk_ptr_ff == CNT_W'(TASK_SLOTS)) && !rd_vld_ff;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign any_fired  = |fired_ff;
   assign cur_fired  = fired_ff[scan_ff];

   // Mark the last beat: no fired slot left, or the cap is reached
   always_comb begin
      fired_rest          = fired_ff;
      fired_rest[scan_ff] = 1'b0;
      cur_last = (fired_rest == '0) || (emit_cnt_ff == RES_W'(MAX_RESULTS - 1));
   end

   // Decrement unit: countdown - 1, or reload with period - 1 at zero
   assign cd_val   = cd_vld_ff[rd_slot_ff]  ? cd_rdata  : '0;
   assign per_val  = per_vld_ff[rd_slot_ff] ? per_rdata : '0;
   assign cd_zero  = (cd_val == '0);
   assign dec_opnd = cd_zero ? per_val : cd_val;
   assign dec_res  = dec_opnd - TIME_W'(1);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept && is_tick) begin
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (walk_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free && (!any_fired || (cur_fired && cur_last))) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath and RAM controls
   always_comb begin
      walk_ptr_in  = walk_ptr_ff;
      rd_vld_in    = 1'b0;
      rd_slot_in   = rd_slot_ff;
      fired_in     = fired_ff;
      scan_in      = scan_ff;
      emit_cnt_in  = emit_cnt_ff;
      active_in    = active_ff;
      present_in   = present_ff;
      cd_vld_in    = cd_vld_ff;
      per_vld_in   = per_vld_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      cd_wr_en     = 1'b0;
      cd_wr_addr   = req_slot;
      cd_wr_data   = req_data.first_delay;
      per_wr_en    = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = walk_ptr_ff[SLOT_W-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (is_tick) begin
                  walk_ptr_in = '0;
                  fired_in    = '0;
                  scan_in     = '0;
                  emit_cnt_in = '0;
               end else if (idx_ok) begin
                  case (req_data.opcode)
                     OP_CREATE: begin
                        cd_wr_en             = 1'b1;
                        per_wr_en            = 1'b1;
                        cd_vld_in[req_slot]  = 1'b1;
                        per_vld_in[req_slot] = 1'b1;
                        present_in[req_slot] = 1'b1;
                        active_in[req_slot]  = 1'b1;
                     end
                     OP_SUSPEND: begin
                        active_in[req_slot] = 1'b0;
                     end
                     OP_RESUME: begin
                        active_in[req_slot] = 1'b1;
                     end
                     OP_DELETE: begin
                        present_in[req_slot] = 1'b0;
                     end
                     default: begin
                     end
                  endcase
               end
            end
         end
         ST_WALK: begin
            // Issue the read for the next slot
            if (walk_ptr_ff != CNT_W'(TASK_SLOTS)) begin
               rd_en       = 1'b1;
               rd_vld_in   = 1'b1;
               rd_slot_in  = walk_ptr_ff[SLOT_W-1:0];
               walk_ptr_in = walk_ptr_ff + CNT_W'(1);
            end
            // Update the slot whose data came back
            if (rd_vld_ff && active_ff[rd_slot_ff]) begin
               cd_wr_en              = 1'b1;
               cd_wr_addr            = rd_slot_ff;
               cd_wr_data            = dec_res;
               cd_vld_in[rd_slot_ff] = 1'b1;
               if (cd_zero && present_ff[rd_slot_ff]) begin
                  fired_in[rd_slot_ff] = 1'b1;
               end
            end
         end
         ST_EMIT: begin
            if (!any_fired) begin
               // Empty tick: one beat with fire low
               if (out_free) begin
                  rsp_valid_in         = 1'b1;
                  rsp_data_in.fire     = 1'b0;
                  rsp_data_in.task_id  = '0;
                  rsp_data_in.last     = 1'b1;
               end
            end else if (cur_fired) begin
               if (out_free) begin
                  rsp_valid_in         = 1'b1;
                  rsp_data_in.fire     = 1'b1;
                  rsp_data_in.task_id  = INDEX_W'(scan_ff);
                  rsp_data_in.last     = cur_last;
                  fired_in[scan_ff]    = 1'b0;
                  emit_cnt_in          = emit_cnt_ff + RES_W'(1);
                  scan_in              = scan_ff + SLOT_W'(1);
                  if (cur_last) begin
                     fired_in = '0;
                  end
               end
            end else begin
               scan_in = scan_ff + SLOT_W'(1);
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         walk_ptr_ff  <= '0;
         rd_vld_ff    <= 1'b0;
         fired_ff     <= '0;
         scan_ff      <= '0;
         emit_cnt_ff  <= '0;
         active_ff    <= '0;
         present_ff   <= '0;
         cd_vld_ff    <= '0;
         per_vld_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         walk_ptr_ff  <= walk_ptr_in;
         rd_vld_ff    <= rd_vld_in;
         fired_ff     <= fired_in;
         scan_ff      <= scan_in;
         emit_cnt_ff  <= emit_cnt_in;
         active_ff    <= active_in;
         present_ff   <= present_in;
         cd_vld_ff    <= cd_vld_in;
         per_vld_ff   <= per_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      rd_slot_ff  <= rd_slot_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Countdown store
   ptts_ram #(
      .WIDTH (TIME_W),
      .DEPTH (TASK_SLOTS),
      .AW    (SLOT_W)
   ) u_cd_ram (
      .clock   (clock),
      .wr_en   (cd_wr_en),
      .wr_addr (cd_wr_addr),
      .wr_data (cd_wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (cd_rdata)
   );

   // Period store
   ptts_ram #(
      .WIDTH (TIME_W),
      .DEPTH (TASK_SLOTS),
      .AW    (SLOT_W)
   ) u_per_ram (
      .clock   (clock),
      .wr_en   (per_wr_en),
      .wr_addr (req_slot),
      .wr_data (req_data.period),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (per_rdata)
   );

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Periodic task tick scheduler testbench
// Drives create, suspend, resume, delete and tick commands into the core,
// keeps its own copy of the slot table to predict the fire beats of each
// tick, and compares every result beat field by field against that forecast.
// ----------------------------------------------------------------------------
module tb_top;
   import ptts_pkg::*;

   localparam int CLK_HALF        = 5;
   localparam int RESET_CYCLES    = 5;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int SETTLE_CYCLES   = 40;
   localparam int HOLD_OFF_CYCLES = 200;
   localparam int RANDOM_ITEMS    = 290;
   localparam int TAIL_ITEMS      = 30;

   // Opcodes the core must ignore
   localparam logic [OPCODE_W-1:0] OP_UNUSED_MIN = 3'd5;
   localparam logic [OPCODE_W-1:0] OP_UNUSED_MAX = 3'd7;
   localparam logic [TIME_W-1:0]   TIME_MAX      = '1;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // Shadow slot table
   logic [TIME_W-1:0] slot_countdown [TASK_SLOTS_DEF] = '{default: '0};
   logic [TIME_W-1:0] slot_period    [TASK_SLOTS_DEF] = '{default: '0};
   bit                slot_active    [TASK_SLOTS_DEF];
   bit                slot_present   [TASK_SLOTS_DEF];

   rsp_type expected_fires_q[$];
   int      error_count       = 0;
   bit      req_pauses_on     = 1'b0;
   bit      rsp_pauses_on     = 1'b0;
   int      rsp_hold_request  = 0;
   int      rsp_stall_left    = 0;

   periodic_task_tick_scheduler_core #(
      .TASK_SLOTS(TASK_SLOTS_DEF)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #CLK_HALF clock = 1'b1;
      #CLK_HALF clock = 1'b0;
   end

   // Update the shadow table for one command; a tick queues its fire beats
   function automatic void apply_command(input req_type cmd);
      rsp_type beat;
      rsp_type fired[$];
      case (cmd.opcode)
         OP_TICK: begin
            for (int s = 0; s < TASK_SLOTS_DEF; s++) begin
               if (slot_active[s]) begin
                  if (slot_countdown[s] == '0) begin
                     if (slot_present[s] && fired.size() < MAX_RESULTS) begin
                        beat.fire    = 1'b1;
                        beat.task_id = INDEX_W'(s);
                        beat.last    = 1'b0;
                        fired.push_back(beat);
                     end
                     slot_countdown[s] = slot_period[s] - 1'b1;
                  end else begin
                     slot_countdown[s] = slot_countdown[s] - 1'b1;
                  end
               end
            end
            // Nothing fired: one beat with fire low
            if (fired.size() == 0) begin
               beat.fire    = 1'b0;
               beat.task_id = '0;
               beat.last    = 1'b1;
               fired.push_back(beat);
            end else begin
               fired[fired.size()-1].last = 1'b1;
            end
            foreach (fired[k]) expected_fires_q.push_back(fired[k]);
         end
         OP_CREATE: begin
            slot_period[cmd.task_index]    = cmd.period;
            slot_countdown[cmd.task_index] = cmd.first_delay;
            slot_present[cmd.task_index]   = 1'b1;
            slot_active[cmd.task_index]    = 1'b1;
         end
         OP_SUSPEND: slot_active[cmd.task_index]  = 1'b0;
         OP_RESUME:  slot_active[cmd.task_index]  = 1'b1;
         OP_DELETE:  slot_present[cmd.task_index] = 1'b0;
         default: ;
      endcase
   endfunction

   // Predict on every accepted command beat
   always @(posedge clock) begin
      if (!reset && req_valid && req_stall === 1'b0) apply_command(req_data);
   end

   // Compare every accepted result beat with the oldest forecast
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (expected_fires_q.size() == 0) begin
            $error("unexpected result beat: fire %0d task_id %0d last %0d",
                   rsp_data.fire, rsp_data.task_id, rsp_data.last);
            error_count++;
         end else begin
            want = expected_fires_q.pop_front();
            if (rsp_data.fire !== want.fire) begin
               $error("fire: expected %0d, actual %0d", want.fire, rsp_data.fire);
               error_count++;
            end
            if (rsp_data.task_id !== want.task_id) begin
               $error("task_id: expected %0d, actual %0d", want.task_id, rsp_data.task_id);
               error_count++;
            end
            if (rsp_data.last !== want.last) begin
               $error("last: expected %0d, actual %0d", want.last, rsp_data.last);
               error_count++;
            end
         end
      end
   end

   // Receiver: random stall bursts, or one long hold-off on request
   always @(posedge clock) begin
      if (rsp_hold_request != 0) begin
         rsp_stall_left   = rsp_hold_request;
         rsp_hold_request = 0;
      end else if (rsp_stall_left == 0 && rsp_pauses_on && $urandom_range(0, 5) == 0) begin
         rsp_stall_left = $urandom_range(1, 8);
      end
      if (rsp_stall_left != 0) begin
         rsp_stall <= 1'b1;
         rsp_stall_left--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // End the run if no beat moves on either channel for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall))
            quiet = 0;
         else
            quiet++;
      end
      $display("Verification failed");
      $finish;
   end

   function automatic req_type make_cmd(input logic [OPCODE_W-1:0] op,
                                        input logic [INDEX_W-1:0]  idx,
                                        input logic [TIME_W-1:0]   per,
                                        input logic [TIME_W-1:0]   dly);
      req_type cmd;
      cmd.opcode      = op;
      cmd.task_index  = idx;
      cmd.period      = per;
      cmd.first_delay = dly;
      return cmd;
   endfunction

   // Mostly ticks and creates with short periods so slots fire often
   function automatic req_type random_cmd();
      req_type cmd;
      int      pick;
      pick = $urandom_range(0, 99);
      cmd  = make_cmd(OP_TICK, INDEX_W'($urandom), TIME_W'($urandom), TIME_W'($urandom));
      if (pick < 45) begin
         cmd.opcode = OP_TICK;
      end else if (pick < 65) begin
         cmd.opcode = OP_CREATE;
         if ($urandom_range(0, 19) != 0) cmd.period = TIME_W'($urandom_range(0, 6));
         if ($urandom_range(0, 19) != 0) cmd.first_delay = TIME_W'($urandom_range(0, 4));
      end else if (pick < 75) begin
         cmd.opcode = OP_SUSPEND;
      end else if (pick < 87) begin
         cmd.opcode = OP_RESUME;
      end else if (pick < 95) begin
         cmd.opcode = OP_DELETE;
      end else begin
         cmd.opcode = OPCODE_W'($urandom_range(OP_UNUSED_MIN, OP_UNUSED_MAX));
      end
      return cmd;
   endfunction

   // Offer one command beat and hold it until accepted
   task automatic send_command(input req_type cmd);
      int gap;
      if (req_pauses_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 8);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= cmd;
      do @(posedge clock); while (req_stall !== 1'b0);
   endtask

   // Drop valid and wait for every forecast beat to arrive
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_fires_q.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed_cases();
      req_pauses_on = 1'b0;
      rsp_pauses_on = 1'b0;
      // Empty tick straight after reset
      send_command(make_cmd(OP_TICK, 3'd0, '0, '0));
      // Immediate fire, period zero wrap and the largest delay
      send_command(make_cmd(OP_CREATE, 3'd0, 16'd1, '0));
      send_command(make_cmd(OP_CREATE, 3'd7, '0, '0));
      send_command(make_cmd(OP_CREATE, 3'd3, TIME_MAX, TIME_MAX));
      send_command(make_cmd(OP_TICK, 3'd0, '0, '0));
      send_command(make_cmd(OP_TICK, 3'd0, '0, '0));
      // Suspend, then delete while still active
      send_command(make_cmd(OP_SUSPEND, 3'd0, '0, '0));
      send_command(make_cmd(OP_TICK, 3'd0, '0, '0));
      send_command(make_cmd(OP_RESUME, 3'd0, '0, '0));
      send_command(make_cmd(OP_DELETE, 3'd0, '0, '0));
      send_command(make_cmd(OP_TICK, 3'd0, '0, '0));
      // Resume a slot that was never created
      send_command(make_cmd(OP_RESUME, 3'd5, '0, '0));
      send_command(make_cmd(OP_TICK, 3'd0, '0, '0));
      // Unknown opcodes do nothing
      for (int op = OP_UNUSED_MIN; op <= OP_UNUSED_MAX; op++)
         send_command(make_cmd(OPCODE_W'(op), INDEX_W'($urandom),
                               TIME_W'($urandom), TIME_W'($urandom)));
      // Every slot fires on the same tick
      for (int s = 0; s < TASK_SLOTS_DEF; s++)
         send_command(make_cmd(OP_CREATE, INDEX_W'(s), 16'd2, '0));
      send_command(make_cmd(OP_TICK, '1, TIME_MAX, TIME_MAX));
      wait_drained();
   endtask

   task automatic test_random_traffic();
      req_pauses_on = 1'b1;
      rsp_pauses_on = 1'b1;
      repeat (RANDOM_ITEMS) send_command(random_cmd());
      wait_drained();
   endtask

   task automatic test_input_backpressure();
      req_pauses_on = 1'b0;
      rsp_pauses_on = 1'b1;
      send_command(make_cmd(OP_CREATE, 3'd2, 16'd1, '0));
      send_command(make_cmd(OP_CREATE, 3'd6, 16'd1, '0));
      send_command(make_cmd(OP_CREATE, 3'd4, 16'd2, 16'd1));
      // Hold the result side while ticks keep coming
      rsp_hold_request = HOLD_OFF_CYCLES;
      repeat (12) send_command(make_cmd(OP_TICK, INDEX_W'($urandom),
                                        TIME_W'($urandom), TIME_W'($urandom)));
      wait_drained();
   endtask

   task automatic test_steady_tail();
      req_pauses_on = 1'b0;
      rsp_pauses_on = 1'b0;
      repeat (TAIL_ITEMS) send_command(random_cmd());
      wait_drained();
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      test_random_traffic();
      test_input_backpressure();
      test_steady_tail();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

// File: filelist.f
hdl/ptts_pkg.sv
hdl/ptts_ram.sv
hdl/periodic_task_tick_scheduler_core.sv
tb/tb_top.sv
